### hw/rtl/hoi_pkg.sv
// shared types and codes for the heater over-temperature interlock
package hoi_pkg;

  localparam int TempW   = 16;
  localparam int ReasonW = 3;
  localparam int BlockW  = 2;
  localparam int ActionW = 2;

  localparam logic signed [TempW-1:0] ThreshReset = 16'sd8000;

  // event kinds
  localparam logic [ActionW-1:0] ACT_SENSOR = 2'd0;
  localparam logic [ActionW-1:0] ACT_HEATER = 2'd1;
  localparam logic [ActionW-1:0] ACT_REARM  = 2'd2;

  // block codes
  localparam logic [BlockW-1:0] BLK_NONE      = 2'd0;
  localparam logic [BlockW-1:0] BLK_NO_SENSOR = 2'd1;
  localparam logic [BlockW-1:0] BLK_INVALID   = 2'd2;
  localparam logic [BlockW-1:0] BLK_LATCHED   = 2'd3;

  // refusal reasons
  localparam logic [ReasonW-1:0] RSN_NONE        = 3'd0;
  localparam logic [ReasonW-1:0] RSN_NO_SENSOR   = 3'd1;
  localparam logic [ReasonW-1:0] RSN_INVALID     = 3'd2;
  localparam logic [ReasonW-1:0] RSN_LATCHED     = 3'd3;
  localparam logic [ReasonW-1:0] RSN_NOT_LATCHED = 3'd4;
  localparam logic [ReasonW-1:0] RSN_TEMP_HIGH   = 3'd5;

  typedef struct packed {
    logic               accepted;
    logic [ReasonW-1:0] reason;
    logic [BlockW-1:0]  block_reason;
    logic               heater_on;
    logic               latched;
    logic               alarm;
  } hoi_result_t;

endpackage

### hw/rtl/hoi_core.sv
// interlock state, threshold register and per-event decision logic
module hoi_core import hoi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic signed [TempW-1:0] cfg_wr_data,
  input  logic                    accept,
  input  logic [ActionW-1:0]      action,
  input  logic                    sensor_found,
  input  logic                    sample_ok,
  input  logic signed [TempW-1:0] temp_cdeg,
  input  logic                    heater_request,
  output hoi_result_t             result
);

  logic signed [TempW-1:0] thresh_r;
  logic                    latch_r, latch_nxt;
  logic                    heater_r, heater_nxt;
  logic                    alarm_r, alarm_nxt;
  logic [BlockW-1:0]       block_r, block_nxt;
  logic                    last_present_r, last_present_nxt;
  logic                    last_valid_r, last_valid_nxt;
  logic signed [TempW-1:0] last_temp_r, last_temp_nxt;
  logic                    acc;
  logic [ReasonW-1:0]      why;
  logic                    new_hot;
  logic                    last_hot;

  assign new_hot  = temp_cdeg >= thresh_r;
  assign last_hot = last_temp_r >= thresh_r;

  always_comb begin
    latch_nxt        = latch_r;
    heater_nxt       = heater_r;
    alarm_nxt        = alarm_r;
    block_nxt        = block_r;
    last_present_nxt = last_present_r;
    last_valid_nxt   = last_valid_r;
    last_temp_nxt    = last_temp_r;
    acc              = 1'b0;
    why              = RSN_NONE;
    unique case (action)
      ACT_SENSOR: begin
        last_present_nxt = sensor_found;
        last_valid_nxt   = sample_ok;
        last_temp_nxt    = temp_cdeg;
        alarm_nxt        = sensor_found & sample_ok & new_hot;
        latch_nxt        = latch_r | alarm_nxt;
        if (latch_nxt) begin
          block_nxt = BLK_LATCHED;
        end else if (!sensor_found) begin
          block_nxt = BLK_NO_SENSOR;
        end else if (!sample_ok) begin
          block_nxt = BLK_INVALID;
        end else begin
          block_nxt = BLK_NONE;
        end
        if (block_nxt != BLK_NONE) begin
          heater_nxt = 1'b0;
        end
        acc = 1'b1;
      end
      ACT_HEATER: begin
        if (!heater_request) begin
          heater_nxt = 1'b0;
          acc        = 1'b1;
        end else if (block_r != BLK_NONE) begin
          why = {1'b0, block_r};
        end else begin
          heater_nxt = 1'b1;
          acc        = 1'b1;
        end
      end
      ACT_REARM: begin
        if (!latch_r) begin
          why = RSN_NOT_LATCHED;
        end else if (!last_present_r) begin
          why = RSN_NO_SENSOR;
        end else if (!last_valid_r) begin
          why = RSN_INVALID;
        end else if (last_hot) begin
          why = RSN_TEMP_HIGH;
        end else begin
          latch_nxt  = 1'b0;
          block_nxt  = BLK_NONE;
          heater_nxt = 1'b0;
          acc        = 1'b1;
        end
      end
      default: begin
        // unused code, nothing changes
      end
    endcase
  end

  always_comb begin
    result.accepted     = acc;
    result.reason       = why;
    result.block_reason = block_nxt;
    result.heater_on    = heater_nxt;
    result.latched      = latch_nxt;
    result.alarm        = alarm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r       <= ThreshReset;
      latch_r        <= 1'b0;
      heater_r       <= 1'b0;
      alarm_r        <= 1'b0;
      block_r        <= BLK_NO_SENSOR;
      last_present_r <= 1'b0;
      last_valid_r   <= 1'b0;
      last_temp_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (accept) begin
        latch_r        <= latch_nxt;
        heater_r       <= heater_nxt;
        alarm_r        <= alarm_nxt;
        block_r        <= block_nxt;
        last_present_r <= last_present_nxt;
        last_valid_r   <= last_valid_nxt;
        last_temp_r    <= last_temp_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_latch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r |-> block_r == BLK_LATCHED)
    else $error("latch set without latched block code");
  a_heater_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
    heater_r |-> block_r == BLK_NONE)
    else $error("heater on while blocked");
  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && action == ACT_REARM && result.accepted) |=> !latch_r && !heater_r)
    else $error("accepted rearm left latch or heater set");
`endif

endmodule

### hw/rtl/hoi_skid.sv
// two-entry output buffer: result register plus skid register
module hoi_skid import hoi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hoi_result_t push_data,
  output logic        push_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output hoi_result_t out_data
);

  logic        out_vld_r;
  logic        skid_vld_r;
  hoi_result_t out_data_r;
  hoi_result_t skid_data_r;
  logic        out_free;

  assign out_free   = !out_vld_r || out_ready;
  assign push_ready = !skid_vld_r;
  assign out_valid  = out_vld_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_vld_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty result register");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> out_vld_r && out_data_r == $past(out_data_r))
    else $error("waiting result beat changed");
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("beat pushed into a full buffer");
`endif

endmodule

### hw/rtl/heater_overtemp_interlock.sv
// top level of the heater over-temperature interlock
// each result is registered, in the skid register if the result register is held
// throughput: one beat per cycle, sustained while out_ready stays high
// in_ready comes only from the skid register, so up to two results can wait on out_*
// reset (rst_n low, synchronous): latch, heater and alarm off, block code no sensor,
// threshold 80.00 degrees, output buffer emptied
module heater_overtemp_interlock import hoi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration: threshold register
  input  logic                    cfg_wr_en,
  input  logic signed [TempW-1:0] cfg_wr_data,
  // event channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ActionW-1:0]      in_action,
  input  logic                    in_sensor_found,
  input  logic                    in_sample_ok,
  input  logic signed [TempW-1:0] in_temp_cdeg,
  input  logic                    in_heater_request,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_accepted,
  output logic [ReasonW-1:0]      out_reason,
  output logic [BlockW-1:0]       out_block_reason,
  output logic                    out_heater_on,
  output logic                    out_latched,
  output logic                    out_alarm
);

  logic        in_beat;
  hoi_result_t core_result;
  hoi_result_t out_data;

  // a beat is taken whenever the skid entry is free
  assign in_beat = in_valid && in_ready;

  // decision logic and interlock state, updated on each accepted beat
  hoi_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (in_beat),
    .action         (in_action),
    .sensor_found   (in_sensor_found),
    .sample_ok      (in_sample_ok),
    .temp_cdeg      (in_temp_cdeg),
    .heater_request (in_heater_request),
    .result         (core_result)
  );

  // result register with skid entry so one more beat can be taken under back-pressure
  hoi_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_beat),
    .push_data  (core_result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_accepted     = out_data.accepted;
  assign out_reason       = out_data.reason;
  assign out_block_reason = out_data.block_reason;
  assign out_heater_on    = out_data.heater_on;
  assign out_latched      = out_data.latched;
  assign out_alarm        = out_data.alarm;

endmodule
